@@ rtl/dmabs_pkg.sv @@
// shared types and constants for the dma axi burst splitter
// no dependencies; imported by every module of the block
package dmabs_pkg;

  localparam int BeatBytesDef = 64;
  localparam int FifoDepthDef = 16;
  localparam int PageBytesDef = 4096;

  // burst limit register and the largest burst
  localparam int          CfgW       = 5;
  localparam int          LimW       = 5;
  localparam int          MaxBurst   = 16;
  localparam logic [4:0]  BurstReset = 5'd16;

  // stream payload widths, padded to whole bytes
  localparam int InW  = 136;
  localparam int OutW = 192;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_RSVD  = 2'd3
  } dmabs_op_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_BEAT   = 2'd1,
    KIND_WRSIZE = 2'd2
  } dmabs_kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BUSY      = 3'd1,
    ST_RANGE     = 3'd2,
    ST_UNALIGNED = 3'd3,
    ST_NARROW    = 3'd4,
    ST_NOTHING   = 3'd5
  } dmabs_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } dmabs_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;   // input item accepted this cycle
    logic beat;   // issue one read beat this cycle
  } dmabs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic read_go;    // offered item is a read burst with beats to issue
    logic beat_last;  // current beat ends the burst
  } dmabs_sts_t;

  // input item fields, source_address in the lowest bits
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] write_offset;
    logic [4:0]  fifo_free;
    logic [31:0] transfer_bytes;
    logic [31:0] destination_address;
    logic [31:0] source_address;
  } dmabs_in_t;

  // result item fields, status in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [4:0]  burst_length;
    logic [63:0] byte_strobe;
    logic [31:0] data_position;
    logic [5:0]  destination_lane;
    logic [5:0]  source_lane;
    logic [6:0]  valid_bytes;
    logic [31:0] bus_destination;
    logic [31:0] bus_source;
    logic [2:0]  status;
  } dmabs_res_t;

endpackage

@@ rtl/dma_axi_burst_splitter_unit.sv @@
// Burst splitter of a copy DMA: checks descriptors and forms AXI read beats
// and write burst sizes.
// Input stream: tuser carries the operation (load, read burst, write burst),
// tdata the descriptor fields, the free FIFO entries and the write offset.
// Output stream: tuser carries the result kind, tlast marks the final result
// of an input item, tdata the status, aligned addresses, lanes and strobe.
// Config channel: one write-only register, the burst limit in beats.
// A load, write-burst or refused item gives one result in the next cycle
// after it is accepted, and the next item can be accepted as soon as the
// output register is free or draining. A read burst is set up when it is
// accepted and then issues one beat per cycle while the output register
// is free or draining; the beat former holds the input meanwhile.
// A single output register parts both sides: a stalled receiver holds the
// pending result and pauses beat issue; input is taken again once it drains.
// Reset clears the descriptor, leaves no burst pending and sets the burst
// limit to 16 beats. No clearing pass is needed.
// Depends on dmabs_pkg, dmabs_ctrl and dmabs_dp.
module dma_axi_burst_splitter_unit #(
  parameter int BEAT_BYTES = dmabs_pkg::BeatBytesDef,
  parameter int FIFO_DEPTH = dmabs_pkg::FifoDepthDef,
  parameter int PAGE_BYTES = dmabs_pkg::PageBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // source_address, destination_address, transfer_bytes, fifo_free,
  // write_offset, zero pad
  input  logic [dmabs_pkg::InW-1:0]   s_axis_tdata_i,
  // operation
  input  logic [1:0]                  s_axis_tuser_i,
  // output stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // status, bus_source, bus_destination, valid_bytes, source_lane,
  // destination_lane, data_position, byte_strobe, burst_length, zero pad
  output logic [dmabs_pkg::OutW-1:0]  m_axis_tdata_o,
  // result_kind
  output logic [1:0]                  m_axis_tuser_o,
  output logic                        m_axis_tlast_o,
  // burst limit register
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dmabs_pkg::CfgW-1:0]  cfg_data_i
);
  import dmabs_pkg::*;

  dmabs_cmd_t  cmd;
  dmabs_sts_t  sts;
  dmabs_kind_e out_kind;
  dmabs_res_t  out_res;
  dmabs_in_t   in_data;
  dmabs_op_e   in_op;

  assign in_data     = dmabs_in_t'(s_axis_tdata_i);
  assign in_op       = dmabs_op_e'(s_axis_tuser_i);
  assign cfg_ready_o = 1'b1;

  dmabs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dmabs_dp #(
    .BEAT_BYTES (BEAT_BYTES),
    .FIFO_DEPTH (FIFO_DEPTH),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_op_i    (in_op),
    .in_data_i  (in_data),
    .out_kind_o (out_kind),
    .out_last_o (m_axis_tlast_o),
    .out_res_o  (out_res)
  );

  assign m_axis_tdata_o = OutW'(out_res);
  assign m_axis_tuser_o = 2'(out_kind);

  // input is only taken when the output slot is free or draining
  a_ready_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input taken while a result is stuck");

  // anything but a read burst answers in the next cycle
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (in_op != OP_READ)) |=> m_axis_tvalid_o)
    else $error("single-result item gave no result");

  // status and write-size results always end their item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_kind != KIND_BEAT)) |-> m_axis_tlast_o)
    else $error("single result without last");

  // a read beat always carries bytes
  a_beat_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_kind == KIND_BEAT)) |-> (out_res.valid_bytes != '0))
    else $error("empty read beat");

endmodule

@@ rtl/dmabs_ctrl.sv @@
// controller state machine of the burst splitter
// sequences input acceptance, read beats and the output register valid
// depends on dmabs_pkg
module dmabs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  input  dmabs_pkg::dmabs_sts_t  sts_i,
  output dmabs_pkg::dmabs_cmd_t  cmd_o
);
  import dmabs_pkg::*;

  dmabs_state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         out_free;

  assign out_free  = !out_valid_q || m_ready_i;
  assign m_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_ready_i;
    cmd_o       = '0;
    s_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = out_free;
        if (s_valid_i && out_free) begin
          cmd_o.take = 1'b1;
          if (sts_i.read_go) begin
            state_d = S_READ;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_READ: begin
        // one beat per cycle while the output slot drains
        if (out_free) begin
          cmd_o.beat  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.beat_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/dmabs_dp.sv @@
// datapath of the burst splitter: descriptor state, load checks,
// read beat former, write burst sizing and the output register
// depends on dmabs_pkg
module dmabs_dp #(
  parameter int BEAT_BYTES = dmabs_pkg::BeatBytesDef,
  parameter int FIFO_DEPTH = dmabs_pkg::FifoDepthDef,
  parameter int PAGE_BYTES = dmabs_pkg::PageBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dmabs_pkg::dmabs_cmd_t       cmd_i,
  output dmabs_pkg::dmabs_sts_t       sts_o,
  input  logic                        cfg_we_i,
  input  logic [dmabs_pkg::CfgW-1:0]  cfg_data_i,
  input  dmabs_pkg::dmabs_op_e        in_op_i,
  input  dmabs_pkg::dmabs_in_t        in_data_i,
  output dmabs_pkg::dmabs_kind_e      out_kind_o,
  output logic                        out_last_o,
  output dmabs_pkg::dmabs_res_t       out_res_o
);
  import dmabs_pkg::*;

  localparam int BW    = $clog2(BEAT_BYTES);
  localparam int PW    = $clog2(PAGE_BYTES);
  localparam int NB_W  = BW + 1;
  localparam int PR_W  = PW + 1;
  localparam int BL_W  = LimW + BW;
  localparam int CW    = (PR_W > BL_W) ? PR_W : BL_W;
  localparam int FF_W  = ($clog2(FIFO_DEPTH + 1) > 5) ? $clog2(FIFO_DEPTH + 1) : 5;
  localparam int BT_W  = 32 - BW + 1;

  // descriptor state
  logic [CfgW-1:0] cfg_q;
  logic            active_q, active_d;
  logic [31:0]     cur_src_q, cur_src_d;
  logic [31:0]     cur_dst_q, cur_dst_d;
  logic [31:0]     dst_base_q, dst_base_d;
  logic [31:0]     len_q, len_d;
  logic [31:0]     pos_q, pos_d;
  logic [31:0]     rem_q, rem_d;
  // burst bookkeeping
  logic [LimW-1:0] limit_q, limit_d;
  logic [LimW-1:0] count_q, count_d;
  logic [BL_W-1:0] byte_limit_q, byte_limit_d;
  logic [BL_W-1:0] issued_q, issued_d;
  // output register
  dmabs_kind_e     kind_q, kind_d;
  logic            last_q, last_d;
  dmabs_res_t      res_q, res_d;

  logic [LimW-1:0] cap;
  // load checks
  logic [31:0]     len_m1;
  logic [BW-1:0]   ld_so, ld_dso;
  logic            ld_big, ld_busy, ld_range, ld_unal, ld_narrow;
  dmabs_status_e   ld_status;
  // read start
  logic [FF_W-1:0] freeb;
  logic [LimW-1:0] rd_limit;
  logic [CW-1:0]   rd_lim_bytes, rd_room;
  // beat former
  logic [BW-1:0]   s_off, d_off;
  logic [PR_W-1:0] pr_s, pr_d, rem_cap, nb_pr;
  logic [NB_W-1:0] nb;
  logic [63:0]     ones, strobe;
  // write sizing
  logic            wr_ok;
  logic [31:0]     wr_rem, wr_dsum, wr_dal;
  logic [BT_W-1:0] wr_beats;
  logic [PR_W-1:0] wr_dbeats;
  logic [31:0]     wr_len;

  // register 0 means one beat, anything above the largest burst is clipped
  always_comb begin
    if (cfg_q == '0) begin
      cap = LimW'(1);
    end else if (32'(cfg_q) > 32'(MaxBurst)) begin
      cap = LimW'(MaxBurst);
    end else begin
      cap = LimW'(cfg_q);
    end
  end

  // load descriptor checks
  always_comb begin
    len_m1   = in_data_i.transfer_bytes - 32'd1;
    ld_so    = in_data_i.source_address[BW-1:0];
    ld_dso   = in_data_i.destination_address[BW-1:0];
    ld_big   = in_data_i.transfer_bytes >= 32'(BEAT_BYTES);
    ld_busy  = active_q && (rem_q != '0);
    ld_range = (in_data_i.transfer_bytes != '0) &&
               ((len_m1 > ~in_data_i.source_address) ||
                (len_m1 > ~in_data_i.destination_address));
    ld_unal  = ld_big && ((ld_so != '0) || (ld_dso != '0));
    ld_narrow = !ld_big && (in_data_i.transfer_bytes != '0) &&
                ((NB_W'(in_data_i.transfer_bytes[BW-1:0]) >
                  NB_W'(BEAT_BYTES) - NB_W'(ld_so)) ||
                 (NB_W'(in_data_i.transfer_bytes[BW-1:0]) >
                  NB_W'(BEAT_BYTES) - NB_W'(ld_dso)));
    priority if (ld_busy)   ld_status = ST_BUSY;
    else if (ld_range)      ld_status = ST_RANGE;
    else if (ld_unal)       ld_status = ST_UNALIGNED;
    else if (ld_narrow)     ld_status = ST_NARROW;
    else                    ld_status = ST_OK;
  end

  // read burst setup and the per-beat former
  always_comb begin
    freeb = (32'(in_data_i.fifo_free) > 32'(FIFO_DEPTH)) ? FF_W'(FIFO_DEPTH)
                                                          : FF_W'(in_data_i.fifo_free);
    rd_limit = (32'(cap) < 32'(freeb)) ? cap : LimW'(freeb);

    s_off = cur_src_q[BW-1:0];
    d_off = cur_dst_q[BW-1:0];
    pr_s  = PR_W'(PAGE_BYTES) - PR_W'(cur_src_q[PW-1:0]);
    pr_d  = PR_W'(PAGE_BYTES) - PR_W'(cur_dst_q[PW-1:0]);

    rd_lim_bytes = CW'({rd_limit, {BW{1'b0}}});
    rd_room      = CW'(pr_s);

    rem_cap = (rem_q >= 32'(BEAT_BYTES)) ? PR_W'(BEAT_BYTES) : PR_W'(rem_q[BW-1:0]);
    nb_pr   = rem_cap;
    if (pr_s < nb_pr) nb_pr = pr_s;
    if (pr_d < nb_pr) nb_pr = pr_d;
    nb = NB_W'(nb_pr);

    ones   = ~({64{1'b1}} << nb);
    strobe = (nb == NB_W'(BEAT_BYTES)) ? ones : (ones << d_off);
  end

  assign sts_o.read_go   = (in_op_i == OP_READ) && active_q && (rem_q != '0) &&
                           (freeb != '0);
  assign sts_o.beat_last = (rem_q == 32'(nb)) ||
                           (LimW'(count_q + LimW'(1)) >= limit_q) ||
                           (BL_W'(issued_q + BL_W'(nb)) >= byte_limit_q);

  // write burst sizing
  always_comb begin
    wr_ok     = active_q && (in_data_i.write_offset < pos_q);
    wr_rem    = len_q - in_data_i.write_offset;
    wr_beats  = BT_W'(wr_rem[31:BW]) + BT_W'(wr_rem[BW-1:0] != '0);
    wr_dsum   = dst_base_q + in_data_i.write_offset;
    wr_dal    = {wr_dsum[31:BW], {BW{1'b0}}};
    wr_dbeats = (PR_W'(PAGE_BYTES) - PR_W'(wr_dal[PW-1:0])) >> BW;
    wr_len    = 32'(cap);
    if (32'(wr_beats) < wr_len)  wr_len = 32'(wr_beats);
    if (32'(wr_dbeats) < wr_len) wr_len = 32'(wr_dbeats);
  end

  // next state
  always_comb begin
    active_d     = active_q;
    cur_src_d    = cur_src_q;
    cur_dst_d    = cur_dst_q;
    dst_base_d   = dst_base_q;
    len_d        = len_q;
    pos_d        = pos_q;
    rem_d        = rem_q;
    limit_d      = limit_q;
    count_d      = count_q;
    byte_limit_d = byte_limit_q;
    issued_d     = issued_q;
    kind_d       = kind_q;
    last_d       = last_q;
    res_d        = res_q;

    if (cmd_i.take) begin
      // status-only result unless overridden below
      kind_d       = KIND_STATUS;
      last_d       = 1'b1;
      res_d        = '0;
      res_d.status = ST_NOTHING;
      unique case (in_op_i)
        OP_LOAD: begin
          res_d.status = ld_status;
          if (ld_status == ST_OK) begin
            active_d   = 1'b1;
            cur_src_d  = in_data_i.source_address;
            cur_dst_d  = in_data_i.destination_address;
            dst_base_d = in_data_i.destination_address;
            len_d      = in_data_i.transfer_bytes;
            rem_d      = in_data_i.transfer_bytes;
            pos_d      = '0;
          end
        end
        OP_READ: begin
          if (sts_o.read_go) begin
            limit_d      = rd_limit;
            count_d      = '0;
            issued_d     = '0;
            byte_limit_d = BL_W'((rd_room < rd_lim_bytes) ? rd_room : rd_lim_bytes);
          end
        end
        OP_WRITE: begin
          if (wr_ok) begin
            kind_d               = KIND_WRSIZE;
            res_d.status         = ST_OK;
            res_d.bus_destination = wr_dal;
            res_d.data_position  = in_data_i.write_offset;
            res_d.burst_length   = 5'(wr_len);
          end
        end
        OP_RSVD: begin
          res_d.status = ST_NOTHING;
        end
        default: begin
          res_d.status = ST_NOTHING;
        end
      endcase
    end

    if (cmd_i.beat) begin
      kind_d                 = KIND_BEAT;
      last_d                 = sts_o.beat_last;
      res_d                  = '0;
      res_d.status           = ST_OK;
      res_d.bus_source       = {cur_src_q[31:BW], {BW{1'b0}}};
      res_d.bus_destination  = {cur_dst_q[31:BW], {BW{1'b0}}};
      res_d.valid_bytes      = 7'(nb);
      res_d.source_lane      = 6'(s_off);
      res_d.destination_lane = 6'(d_off);
      res_d.data_position    = pos_q;
      res_d.byte_strobe      = strobe;
      cur_src_d              = cur_src_q + 32'(nb);
      cur_dst_d              = cur_dst_q + 32'(nb);
      pos_d                  = pos_q + 32'(nb);
      rem_d                  = rem_q - 32'(nb);
      count_d                = LimW'(count_q + LimW'(1));
      issued_d               = BL_W'(issued_q + BL_W'(nb));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= BurstReset;
      active_q   <= 1'b0;
      cur_src_q  <= '0;
      cur_dst_q  <= '0;
      dst_base_q <= '0;
      len_q      <= '0;
      pos_q      <= '0;
      rem_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      active_q   <= active_d;
      cur_src_q  <= cur_src_d;
      cur_dst_q  <= cur_dst_d;
      dst_base_q <= dst_base_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
      rem_q      <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q      <= limit_d;
    count_q      <= count_d;
    byte_limit_q <= byte_limit_d;
    issued_q     <= issued_d;
    kind_q       <= kind_d;
    last_q       <= last_d;
    res_q        <= res_d;
  end

  assign out_kind_o = kind_q;
  assign out_last_o = last_q;
  assign out_res_o  = res_q;

endmodule
